// File: rtl/wbps_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register indexes and beat types of the wildcard byte pattern scanner.
package wbps_pkg;

  localparam int unsigned PatternMaxDef = 32;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned BytesPerReg   = 8;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 64;
  localparam int unsigned LenW          = 6;
  localparam int unsigned CountW        = 32;
  localparam int unsigned AddrW         = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAT_LOW      = 3'd0,
    CFG_PAT_MID_LOW  = 3'd1,
    CFG_PAT_MID_HIGH = 3'd2,
    CFG_PAT_HIGH     = 3'd3,
    CFG_WILD_MASK    = 3'd4,
    CFG_PAT_LEN      = 3'd5,
    CFG_BASE_ADDR    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             region_end;
  } in_beat_t;

  typedef struct packed {
    logic [CountW-1:0] match_count;
    logic [AddrW-1:0]  match_address;
    logic              match_seen;
  } out_beat_t;

endpackage

// File: rtl/wbps_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interface that carries one beat of a given payload type.
interface wbps_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/wbps_cell.sv
`timescale 1ns / 1ps
// One cell of the shift-and chain: compares one pattern position and holds one partial-match bit.
module wbps_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      clear_i,
  input  logic [wbps_pkg::ByteW-1:0] data_byte_i,
  input  logic [wbps_pkg::ByteW-1:0] pat_byte_i,
  input  logic                      wild_i,
  input  logic                      prev_i,
  output logic                      match_d_o,
  output logic                      match_q_o
);
  import wbps_pkg::*;

  logic match_q;

  assign match_d_o = prev_i & (wild_i | (data_byte_i == pat_byte_i));
  assign match_q_o = match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (step_i) begin
      match_q <= clear_i ? 1'b0 : match_d_o;
    end
  end
endmodule

// File: rtl/wbps_tally.sv
`timescale 1ns / 1ps
// Match counter, position tracking and two-entry result buffer at the end of the cell chain.
module wbps_tally #(
  parameter int unsigned IdxW = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       last_i,
  input  logic                       hit_i,
  input  logic [IdxW-1:0]            lenm1_i,
  input  logic [wbps_pkg::AddrW-1:0] base_i,
  output logic                       in_ready_o,
  wbps_stream_if.source              out_if
);
  import wbps_pkg::*;

  logic [AddrW-1:0]  pos_q;
  logic [AddrW-1:0]  start_q, start_d;
  logic [CountW-1:0] count_q, count_d;
  logic              seen_q, seen_d;
  logic [AddrW-1:0]  addr_d;
  out_beat_t         res_d;
  out_beat_t         out_q;
  out_beat_t         skid_q;
  logic              out_valid_q;
  logic              skid_valid_q;
  logic              push;
  logic              pop;

  always_comb begin
    count_d = count_q;
    if (hit_i && (count_q != {CountW{1'b1}})) begin
      count_d = count_q + CountW'(1);
    end
    seen_d  = seen_q | hit_i;
    start_d = hit_i ? (pos_q - AddrW'(lenm1_i)) : start_q;
    if (hit_i) begin
      addr_d = base_i + pos_q - AddrW'(lenm1_i);
    end else begin
      addr_d = base_i + start_q;
    end
    res_d.match_count   = count_d;
    res_d.match_address = seen_d ? addr_d : '0;
    res_d.match_seen    = seen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      start_q <= '0;
      count_q <= '0;
      seen_q  <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        pos_q   <= '0;
        start_q <= '0;
        count_q <= '0;
        seen_q  <= 1'b0;
      end else begin
        pos_q   <= pos_q + AddrW'(1);
        start_q <= start_d;
        count_q <= count_d;
        seen_q  <= seen_d;
      end
    end
  end

  assign push       = step_i & last_i;
  assign pop        = out_valid_q & out_if.ready;
  assign in_ready_o = ~skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= push;
      end else begin
        out_valid_q  <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (push) begin
          skid_q <= res_d;
        end
      end else if (push) begin
        out_q <= res_d;
      end
    end else if (push) begin
      skid_q <= res_d;
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;
endmodule

// File: rtl/wildcard_byte_pattern_scan_top.sv
`timescale 1ns / 1ps
// Top level of the wildcard byte pattern scanner: configuration registers and the cell chain.
//
//   Port      Dir   Handshake      Payload
//   in_if     in    valid/ready    data_byte, region_end
//   out_if    out   valid/ready    match_count, match_address, match_seen
//   cfg_*     in    write enable   index, 64-bit data
//
// One byte is taken every cycle while in_if is not stalled; the cell chain updates all partial-match bits at once.
// The beat that carries region_end pushes the region's result into the output buffer, which offers it on out_if.
// Two result entries buffer the output; in_if stalls only while both are full.
// Reset clears the chain, the counters and the registers to their defaults.
module wildcard_byte_pattern_scan_top #(
  parameter int unsigned PatternMax = wbps_pkg::PatternMaxDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  wbps_stream_if.sink                   in_if,
  wbps_stream_if.source                 out_if,
  input  logic                          cfg_we_i,
  input  logic [wbps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wbps_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import wbps_pkg::*;

  localparam int unsigned IdxW = (PatternMax > 1) ? $clog2(PatternMax) : 1;

  logic [ByteW-1:0]      pat_q [PatternMax];
  logic [PatternMax-1:0] wild_q;
  logic [LenW-1:0]       len_q;
  logic [AddrW-1:0]      base_q;
  logic [LenW-1:0]       len_eff;
  logic [IdxW-1:0]       lenm1;
  logic [PatternMax-1:0] vec_q;
  logic [PatternMax-1:0] vec_d;
  logic                  step;
  logic                  last;
  logic                  hit;
  logic                  in_ready;

  assign step        = in_if.valid & in_ready;
  assign last        = in_if.payload.region_end;
  assign in_if.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PatternMax; k++) begin
        pat_q[k] <= '0;
      end
      wild_q <= '0;
    end else if (cfg_we_i) begin
      for (int k = 0; k < PatternMax; k++) begin
        if (cfg_idx_i == CfgIdxW'(int'(CFG_PAT_LOW) + k / BytesPerReg)) begin
          pat_q[k] <= cfg_wdata_i[(k % BytesPerReg) * ByteW +: ByteW];
        end
      end
      if (cfg_idx_i == CFG_WILD_MASK) begin
        wild_q <= cfg_wdata_i[PatternMax-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LenW'(1);
      base_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_PAT_LEN) begin
        len_q <= cfg_wdata_i[LenW-1:0];
      end
      if (cfg_idx_i == CFG_BASE_ADDR) begin
        base_q <= cfg_wdata_i[AddrW-1:0];
      end
    end
  end

  always_comb begin
    len_eff = len_q;
    if (len_q == '0) begin
      len_eff = LenW'(1);
    end else if (len_q > LenW'(PatternMax)) begin
      len_eff = LenW'(PatternMax);
    end
    lenm1 = IdxW'(len_eff - LenW'(1));
  end

  for (genvar k = 0; k < PatternMax; k++) begin : g_cell
    logic prev;
    if (k == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = vec_q[k-1];
    end

    wbps_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (step),
      .clear_i     (last),
      .data_byte_i (in_if.payload.data_byte),
      .pat_byte_i  (pat_q[k]),
      .wild_i      (wild_q[k]),
      .prev_i      (prev),
      .match_d_o   (vec_d[k]),
      .match_q_o   (vec_q[k])
    );
  end

  assign hit = vec_d[lenm1];

  wbps_tally #(
    .IdxW (IdxW)
  ) u_tally (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .last_i     (last),
    .hit_i      (hit),
    .lenm1_i    (lenm1),
    .base_i     (base_q),
    .in_ready_o (in_ready),
    .out_if     (out_if)
  );

  a_last_clears_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && last |=> vec_q == '0)
    else $error("Partial-match chain not cleared after the final beat of a region.");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && last |=> out_if.valid)
    else $error("No result pending after the final beat of a region.");

  a_mid_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !last && !out_if.valid |=> !out_if.valid)
    else $error("Result appeared without a final beat.");

  a_unseen_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.payload.match_seen |->
      (out_if.payload.match_count == '0) && (out_if.payload.match_address == '0))
    else $error("Result without a match carries a nonzero count or address.");
endmodule
